// ===== hdl/e2a_pkg.sv =====
// Shared types and sine-kernel coefficients for the Euler-to-axis-vector block.
package e2a_pkg;

  localparam int QBits   = 30;
  localparam int NumOut  = 9;
  localparam int FieldW  = 16;
  localparam int NumCell = 6;

  // pi/2 in Q30 and its square rounded to Q30
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [63:0] HalfPiSq  = (HalfPiQ30 * HalfPiQ30 + (64'd1 << 29)) >> 30;

  // Odd Taylor coefficients of sin(pi/2 * u), Q30, truncated step by step
  localparam logic [63:0] SinCoef0 = HalfPiQ30;
  localparam logic [63:0] SinCoef1 = ((SinCoef0 * HalfPiSq) >> 30) / 64'd6;
  localparam logic [63:0] SinCoef2 = ((SinCoef1 * HalfPiSq) >> 30) / 64'd20;
  localparam logic [63:0] SinCoef3 = ((SinCoef2 * HalfPiSq) >> 30) / 64'd42;
  localparam logic [63:0] SinCoef4 = ((SinCoef3 * HalfPiSq) >> 30) / 64'd72;
  localparam logic [63:0] SinCoef5 = ((SinCoef4 * HalfPiSq) >> 30) / 64'd110;
  localparam logic [63:0] SinCoef6 = ((SinCoef5 * HalfPiSq) >> 30) / 64'd156;

  // Word handed from one sine cell to the next
  typedef struct packed {
    logic [QBits:0] u;    // position in quarter wave, Q30, up to 2^30
    logic [QBits:0] z;    // u^2, Q30
    logic [QBits:0] t;    // Horner partial sum, Q30
    logic           neg;  // negate the final sine
  } horner_t;

  // Odd Taylor coefficient k of sin(pi/2 * u), Q30
  function automatic logic [QBits:0] sin_coef(input int k);
    logic [63:0] c;
    case (k)
      0:       c = SinCoef0;
      1:       c = SinCoef1;
      2:       c = SinCoef2;
      3:       c = SinCoef3;
      4:       c = SinCoef4;
      5:       c = SinCoef5;
      default: c = SinCoef6;
    endcase
    return c[QBits:0];
  endfunction

endpackage

// ===== hdl/e2a_horner_cell.sv =====
// One Horner step of the quarter-wave sine polynomial, registered.
module e2a_horner_cell import e2a_pkg::*; #(
  parameter int K = 0
) (
  input  logic    clk_i,
  input  logic    en_i,
  input  horner_t cell_i,
  output horner_t cell_o
);

  localparam logic [QBits:0] Coef = sin_coef(K);

  logic [2*QBits+1:0] prod;
  logic [QBits+1:0]   sub;
  horner_t            cell_d, cell_q;

  always_comb begin
    prod   = cell_i.z * cell_i.t;
    sub    = prod[2*QBits+1:QBits];
    cell_d = cell_i;
    // clamp the partial sum at zero
    cell_d.t = (sub > {1'b0, Coef}) ? '0 : Coef - sub[QBits:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) cell_q <= cell_d;
  end

  assign cell_o = cell_q;

endmodule

// ===== hdl/e2a_sine_lane.sv =====
// Sine (or cosine) of one binary angle: quadrant fold, square, six Horner cells, scale.
module e2a_sine_lane import e2a_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter bit COS        = 1'b0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [FieldW-1:0]  angle_i,
  output logic signed [31:0] sine_o
);

  logic [ANGLE_BITS-1:0] a;
  logic [QBits-1:0]      pos;
  horner_t               prep_d, prep_q, sq_d, sq_q;
  horner_t               chain [NumCell+1];
  logic [2*QBits+1:0]    sq_prod, fin_prod;
  logic [31:0]           mag;
  logic signed [31:0]    sine_d, sine_q;

  always_comb begin
    a = ANGLE_BITS'(angle_i);
    if (COS) a = a + {2'b01, {(ANGLE_BITS-2){1'b0}}};
    pos = {a[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
    prep_d     = '0;
    prep_d.neg = a[ANGLE_BITS-1];
    // reflect odd quadrants
    prep_d.u   = a[ANGLE_BITS-2] ? (31'd1 << QBits) - {1'b0, pos} : {1'b0, pos};
  end

  always_comb begin
    sq_prod = prep_q.u * prep_q.u;
    sq_d    = prep_q;
    sq_d.z  = sq_prod[2*QBits:QBits];
    sq_d.t  = sin_coef(NumCell);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q <= prep_d;
      sq_q   <= sq_d;
    end
  end

  assign chain[0] = sq_q;

  for (genvar g = 0; g < NumCell; g++) begin : g_cell
    e2a_horner_cell #(.K(NumCell - 1 - g)) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .cell_i(chain[g]),
      .cell_o(chain[g+1])
    );
  end

  always_comb begin
    fin_prod = chain[NumCell].u * chain[NumCell].t;
    mag      = fin_prod[2*QBits+1:QBits];
    sine_d   = chain[NumCell].neg ? -$signed(mag) : $signed(mag);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) sine_q <= sine_d;
  end

  assign sine_o = sine_q;

endmodule

// ===== hdl/e2a_vec.sv =====
// Basis-vector products, sums, rounding and saturation over four registered stages.
module e2a_vec import e2a_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] sy_i,
  input  logic signed [31:0] cy_i,
  input  logic signed [31:0] sp_i,
  input  logic signed [31:0] cp_i,
  input  logic signed [31:0] sr_i,
  input  logic signed [31:0] cr_i,
  output logic [FieldW-1:0]  comp_o [NumOut]
);

  localparam int Shift = 2 * QBits - FRAC_BITS;

  typedef logic signed [61:0] q60_t;
  typedef logic signed [62:0] sum_t;

  function automatic logic signed [31:0] round_q30(input q60_t v);
    logic [61:0] m;
    m = v[61] ? 62'(-v) : 62'(v);
    m = (m + (62'd1 << (QBits - 1))) >> QBits;
    return v[61] ? -$signed(m[31:0]) : $signed(m[31:0]);
  endfunction

  function automatic logic [FieldW-1:0] to_field(input sum_t v);
    logic [62:0] m;
    logic [62:0] r;
    m = v[62] ? 63'(-v) : 63'(v);
    m = (m + (63'd1 << (Shift - 1))) >> Shift;
    if (m > (63'd1 << FRAC_BITS)) m = 63'd1 << FRAC_BITS;
    r = v[62] ? -m : m;
    return r[FieldW-1:0];
  endfunction

  // stage A: pairwise products
  q60_t a_sycp_q, a_sp_q, a_cycp_q, a_srcp_q, a_crcp_q;
  q60_t a_crcy_q, a_crsy_q, a_srcy_q, a_srsy_q;
  logic signed [31:0] a_srsp_q, a_crsp_q, a_sy_q, a_cy_q;
  // stage B: triple products
  q60_t b_sycp_q, b_sp_q, b_cycp_q, b_srcp_q, b_crcp_q;
  q60_t b_crcy_q, b_crsy_q, b_srcy_q, b_srsy_q;
  q60_t b_srspsy_q, b_srspcy_q, b_crspsy_q, b_crspcy_q;
  // stage C: sums; stage D: fields
  sum_t c_sum_q [NumOut];
  logic [FieldW-1:0] d_comp_q [NumOut];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_sycp_q <= sy_i * cp_i;
      a_sp_q   <= q60_t'(sp_i) <<< QBits;
      a_cycp_q <= cy_i * cp_i;
      a_srcp_q <= sr_i * cp_i;
      a_crcp_q <= cr_i * cp_i;
      a_crcy_q <= cr_i * cy_i;
      a_crsy_q <= cr_i * sy_i;
      a_srcy_q <= sr_i * cy_i;
      a_srsy_q <= sr_i * sy_i;
      a_srsp_q <= round_q30(q60_t'(sr_i) * q60_t'(sp_i));
      a_crsp_q <= round_q30(q60_t'(cr_i) * q60_t'(sp_i));
      a_sy_q   <= sy_i;
      a_cy_q   <= cy_i;

      b_sycp_q   <= a_sycp_q;
      b_sp_q     <= a_sp_q;
      b_cycp_q   <= a_cycp_q;
      b_srcp_q   <= a_srcp_q;
      b_crcp_q   <= a_crcp_q;
      b_crcy_q   <= a_crcy_q;
      b_crsy_q   <= a_crsy_q;
      b_srcy_q   <= a_srcy_q;
      b_srsy_q   <= a_srsy_q;
      b_srspsy_q <= a_srsp_q * a_sy_q;
      b_srspcy_q <= a_srsp_q * a_cy_q;
      b_crspsy_q <= a_crsp_q * a_sy_q;
      b_crspcy_q <= a_crsp_q * a_cy_q;

      c_sum_q[0] <= sum_t'(b_sycp_q);
      c_sum_q[1] <= sum_t'(b_sp_q);
      c_sum_q[2] <= sum_t'(b_cycp_q);
      c_sum_q[3] <= sum_t'(b_srspsy_q) + sum_t'(b_crcy_q);
      c_sum_q[4] <= sum_t'(b_srcp_q);
      c_sum_q[5] <= sum_t'(b_srspcy_q) - sum_t'(b_crsy_q);
      c_sum_q[6] <= sum_t'(b_crspsy_q) - sum_t'(b_srcy_q);
      c_sum_q[7] <= sum_t'(b_crcp_q);
      c_sum_q[8] <= sum_t'(b_crspcy_q) + sum_t'(b_srsy_q);

      for (int i = 0; i < NumOut; i++) d_comp_q[i] <= to_field(c_sum_q[i]);
    end
  end

  assign comp_o = d_comp_q;

endmodule

// ===== hdl/euler_to_axis_vectors_top.sv =====
// Euler angles to forward, right and up vectors: top level with stream ports.
//
// Input channel s_axis carries one orientation per transfer: yaw, pitch and
// roll as binary angles (2^ANGLE_BITS units per turn, low bits of each
// 16-bit field used). Output channel m_axis carries the nine Q1.FRAC_BITS
// components of the forward, right and up vectors for that orientation.
// Items are independent and one result leaves for every input transfer,
// in order.
// From input transfer to output valid an item passes the quadrant fold and
// squaring registers, six Horner cells, one scaling cell, and the product,
// sum and rounding stages. Throughput is one item per cycle while the
// receiver does not stall; the six sine/cosine lanes and the product stages
// are fully pipelined. When the receiver stalls with a result waiting, the
// whole pipeline holds and s_axis_tready drops in the same cycle; bubbles
// move on otherwise. Reset clears all valid bits, so no result appears until
// a transfer is taken; data registers are not reset.
module euler_to_axis_vectors_top import e2a_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // yaw_angle, pitch_angle, roll_angle (16 bits each, lowest first)
  input  logic [47:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // forward_x, forward_y, forward_z, right_x, right_y, right_z,
  // up_x, up_y, up_z (16 bits each, lowest first)
  output logic [143:0] m_axis_tdata
);

  localparam int Lat = 3 + NumCell + 4;

  logic               en;
  logic [Lat-1:0]     vld_d, vld_q;
  logic signed [31:0] trig [6];
  logic [FieldW-1:0]  comp [NumOut];

  assign en            = !vld_q[Lat-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[Lat-1];
  assign vld_d         = {vld_q[Lat-2:0], s_axis_tvalid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // lanes: sin/cos of yaw, pitch, roll
  for (genvar g = 0; g < 6; g++) begin : g_lane
    e2a_sine_lane #(.ANGLE_BITS(ANGLE_BITS), .COS(g % 2 == 1)) u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .angle_i(s_axis_tdata[16*(g/2) +: 16]),
      .sine_o (trig[g])
    );
  end

  e2a_vec #(.FRAC_BITS(FRAC_BITS)) u_vec (
    .clk_i (clk_i),
    .en_i  (en),
    .sy_i  (trig[0]),
    .cy_i  (trig[1]),
    .sp_i  (trig[2]),
    .cp_i  (trig[3]),
    .sr_i  (trig[4]),
    .cr_i  (trig[5]),
    .comp_o(comp)
  );

  for (genvar g = 0; g < NumOut; g++) begin : g_out
    assign m_axis_tdata[16*g +: 16] = comp[g];
  end

  // a waiting, stalled result blocks new transfers
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  // an empty output stage never refuses input
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input refused with empty output stage");

  // forward_y is saturated to plus or minus one
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && FRAC_BITS <= 14 |->
      $signed(m_axis_tdata[31:16]) <= $signed(17'(1 << FRAC_BITS)) &&
      $signed(m_axis_tdata[31:16]) >= -$signed(17'(1 << FRAC_BITS)))
    else $error("component outside saturation range");

  // a result appears only after a transfer entered the pipeline
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(vld_q[Lat-2]))
    else $error("result without input");

endmodule

// ===== dv/tb_euler_to_axis_vectors_top.sv =====
// Testbench for the Euler-angle to forward/right/up vector block.
`timescale 1ns / 1ps

module tb_euler_to_axis_vectors_top;

  localparam int AngleBits = 16;
  localparam int FracBits  = 14;
  localparam int NumComp   = 9;
  localparam int IdleLimit = 20000;
  localparam int Latency   = 13;

  typedef logic [15:0] vec_t [NumComp];
  typedef logic [16*NumComp-1:0] word_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;

  word_t pending_vectors [$];
  int    err_cnt;
  int    idle_cycles;
  bit    timed_out;
  int    stall_mode;

  euler_to_axis_vectors_top #(.ANGLE_BITS(AngleBits), .FRAC_BITS(FracBits)) dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Sine kernel, Q30, on the quarter-wave position
  function automatic longint unsigned kernel_sin(longint unsigned u);
    longint unsigned c [7];
    longint unsigned p, z, t, sub, n;
    c[0] = 64'd1686629713;
    p = (c[0] * c[0] + (64'd1 << 29)) >> 30;
    for (int k = 1; k < 7; k++) begin
      n = 2 * k;
      c[k] = ((c[k-1] * p) >> 30) / (n * (n + 1));
    end
    if (u > (64'd1 << 30)) u = 64'd1 << 30;
    z = (u * u) >> 30;
    t = c[6];
    for (int k = 5; k >= 0; k--) begin
      sub = (z * t) >> 30;
      t = (sub > c[k]) ? 64'd0 : c[k] - sub;
    end
    return (u * t) >> 30;
  endfunction

  function automatic longint sin_q30(longint unsigned ang);
    longint unsigned a, quad, u, s;
    a = ang & ((64'd1 << AngleBits) - 1);
    quad = (a >> (AngleBits - 2)) & 3;
    u = (a & ((64'd1 << (AngleBits - 2)) - 1)) << (32 - AngleBits);
    if (quad[0]) u = (64'd1 << 30) - u;
    s = kernel_sin(u);
    return quad[1] ? -longint'(s) : longint'(s);
  endfunction

  function automatic longint round_q30(longint v);
    longint unsigned m;
    m = ((v < 0 ? -v : v) + (64'd1 << 29)) >> 30;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  // Round a Q60 sum to the output format and saturate
  function automatic logic [15:0] q60_to_comp(longint v);
    longint unsigned m, lim;
    longint r;
    lim = 64'd1 << FracBits;
    m = ((v < 0 ? -v : v) + (64'd1 << (59 - FracBits))) >> (60 - FracBits);
    if (m > lim) m = lim;
    r = v < 0 ? -longint'(m) : longint'(m);
    return r[15:0];
  endfunction

  function automatic word_t predict_vectors(logic [15:0] yaw, logic [15:0] pitch,
                                            logic [15:0] roll);
    longint sy, cy, sp, cp, sr, cr, srsp, crsp;
    longint quarter;
    vec_t v;
    word_t w;
    quarter = 64'd1 << (AngleBits - 2);
    sy = sin_q30(yaw);   cy = sin_q30(yaw + quarter);
    sp = sin_q30(pitch); cp = sin_q30(pitch + quarter);
    sr = sin_q30(roll);  cr = sin_q30(roll + quarter);
    srsp = round_q30(sr * sp);
    crsp = round_q30(cr * sp);
    v[0] = q60_to_comp(sy * cp);
    v[1] = q60_to_comp(sp * (64'sd1 << 30));
    v[2] = q60_to_comp(cy * cp);
    v[3] = q60_to_comp(srsp * sy + cr * cy);
    v[4] = q60_to_comp(sr * cp);
    v[5] = q60_to_comp(srsp * cy - cr * sy);
    v[6] = q60_to_comp(crsp * sy - sr * cy);
    v[7] = q60_to_comp(cr * cp);
    v[8] = q60_to_comp(crsp * cy + sr * sy);
    for (int i = 0; i < NumComp; i++) w[16*i +: 16] = v[i];
    return w;
  endfunction

  // Send one orientation, with random gaps between bursts
  int burst_left;
  task automatic send_angles(logic [15:0] yaw, logic [15:0] pitch, logic [15:0] roll);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 30);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {roll, pitch, yaw};
    pending_vectors.push_back(predict_vectors(yaw, pitch, roll));
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
  endtask

  task automatic test_extremes();
    logic [15:0] vals [8] = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                              16'hC000, 16'h3FFF, 16'h2000, 16'h7FFF};
    for (int i = 0; i < 8; i++) send_angles(vals[i], vals[(i + 3) % 8], vals[(i + 5) % 8]);
    for (int i = 0; i < 8; i++) send_angles(vals[i], vals[i], vals[i]);
    // pitch at straight up or down saturates the forward vector
    send_angles(16'h1234, 16'h4000, 16'h9ABC);
    send_angles(16'hFEDC, 16'hC000, 16'h0001);
  endtask

  task automatic test_random_angles(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 7) == 0)
        send_angles(16'($urandom_range(0, 3)) << 14, 16'($urandom_range(0, 3)) << 14,
                    16'($urandom_range(0, 3)) << 14);
      else
        send_angles(16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  // Receiver stall pattern, switching between modes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_mode    <= 0;
    end else begin
      if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    word_t exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_vectors.size() == 0) begin
        $error("result transfer with no prediction pending: %h", m_axis_tdata);
        err_cnt++;
      end else begin
        exp_w = pending_vectors.pop_front();
        for (int i = 0; i < NumComp; i++)
          if (m_axis_tdata[16*i +: 16] !== exp_w[16*i +: 16]) begin
            $error("%s: expected %0d, got %0d",
                   i == 0 ? "forward_x" : i == 1 ? "forward_y" : i == 2 ? "forward_z" :
                   i == 3 ? "right_x" : i == 4 ? "right_y" : i == 5 ? "right_z" :
                   i == 6 ? "up_x" : i == 7 ? "up_y" : "up_z",
                   $signed(exp_w[16*i +: 16]), $signed(m_axis_tdata[16*i +: 16]));
            err_cnt++;
          end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) timed_out = 1'b1;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    err_cnt       = 0;
    idle_cycles   = 0;
    timed_out     = 1'b0;
    burst_left    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      begin
        test_extremes();
        test_random_angles(1730);
        s_axis_tvalid <= 1'b0;
        while (pending_vectors.size() != 0) @(posedge clk_i);
        repeat (Latency + 5) @(posedge clk_i);
      end
      wait (timed_out);
    join_any
    if (timed_out) begin
      $display("Testbench completed WITH ERRORS");
    end else if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/e2a_pkg.sv
hdl/e2a_horner_cell.sv
hdl/e2a_sine_lane.sv
hdl/e2a_vec.sv
hdl/euler_to_axis_vectors_top.sv
dv/tb_euler_to_axis_vectors_top.sv
